/* rtl/ple_pkg.sv */
// Package: constants, request codes, queue entry type and sequencer states.
package ple_pkg;
  localparam int Capacity = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_PRINT  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SHOW   = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] pos;
    logic [15:0] end_pos;
    logic [15:0] value;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_COMPACT,
    ST_READ,
    ST_EMIT,
    ST_DROP
  } state_t;
endpackage

/* rtl/ple_front.sv */
// Front end: accepts requests, drops unused codes, queues the rest.
module ple_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  ple_pkg::req_t s_req,
  output logic          q_valid,
  input  logic          q_ready,
  output ple_pkg::req_t q_req
);
  import ple_pkg::*;

  req_t        buf_q [QDepth];
  logic        wp, rp;
  logic [1:0]  fill;
  logic        push, pop, legal;

  assign legal   = (s_req.op == OP_INSERT) || (s_req.op == OP_ERASE) ||
                   (s_req.op == OP_PRINT) || (s_req.op == OP_REMOVE) ||
                   (s_req.op == OP_SHOW);
  assign s_ready = (fill != 2'(QDepth));
  assign push    = s_valid && s_ready && legal;
  assign q_valid = (fill != 2'd0);
  assign q_req   = buf_q[rp];
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_q[wp] <= s_req;
  end
endmodule

/* rtl/ple_back.sv */
// Back end: list memory and the sequencer that shifts, compacts and reads it.
module ple_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  ple_pkg::req_t q_req,
  output logic          m_valid,
  input  logic          m_ready,
  output logic [15:0]   m_value,
  output logic          m_last,
  output logic          m_status
);
  import ple_pkg::*;

  logic [15:0]   mem [Capacity];
  state_t        state, state_next;
  req_t          req;
  logic [CntW-1:0] count, rd, wr, stop;
  logic [15:0]   rdata;
  logic          rvalid;     // rdata holds mem[rd-1]
  logic          out_full;
  logic [CntW-1:0] ins_p, ers_e, prt_p;
  logic          busy_out;
  logic          load;       // output register takes a new item this cycle

  assign ins_p = (q_req.pos > 16'(count)) ? count : CntW'(q_req.pos);
  assign ers_e = (q_req.end_pos > 16'(count)) ? count : CntW'(q_req.end_pos);
  assign prt_p = (q_req.pos > 16'(count - 1'b1)) ? count - 1'b1 : CntW'(q_req.pos);
  assign busy_out = out_full && !m_ready;
  assign load = !busy_out && (state == ST_EMIT || state == ST_DROP);
  assign q_ready = (state == ST_IDLE) && !out_full;
  assign m_valid = out_full;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid && q_ready) begin
        case (q_req.op)
          OP_INSERT: state_next = (count == CntW'(Capacity)) ? ST_DROP : ST_SHIFT;
          OP_ERASE:  state_next = (16'(ers_e) > q_req.pos) ? ST_COMPACT : ST_IDLE;
          OP_REMOVE: state_next = ST_COMPACT;
          OP_PRINT, OP_SHOW: state_next = (count == '0) ? ST_IDLE : ST_READ;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SHIFT: if (wr == stop) state_next = ST_IDLE;
      ST_COMPACT: if (rd == count && !rvalid) state_next = ST_IDLE;
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: if (!busy_out) state_next = (rd == stop) ? ST_IDLE : ST_READ;
      ST_DROP: if (!busy_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_full <= 1'b0;
      rvalid <= 1'b0;
      rd <= '0;
      wr <= '0;
      stop <= '0;
    end else begin
      state <= state_next;
      if (out_full && m_ready && !load) out_full <= 1'b0;
      case (state)
        ST_IDLE: if (q_valid && q_ready) begin
          req <= q_req;
          rvalid <= 1'b0;
          case (q_req.op)
            OP_INSERT: begin
              wr <= count;
              stop <= ins_p;  // insert slot
            end
            OP_ERASE: begin
              wr <= CntW'(q_req.pos);
              rd <= ers_e;
              stop <= ers_e;
            end
            OP_REMOVE: begin
              wr <= '0;
              rd <= '0;
            end
            OP_PRINT: begin
              rd <= prt_p;
              stop <= prt_p + 1'b1;
            end
            default: begin
              rd <= '0;
              stop <= count;
            end
          endcase
        end
        ST_SHIFT: begin
          if (wr == stop) begin
            mem[wr[IdxW-1:0]] <= req.value;
            count <= count + 1'b1;
          end else begin
            mem[wr[IdxW-1:0]] <= mem[IdxW'(wr - 1'b1)];
            wr <= wr - 1'b1;
          end
        end
        ST_COMPACT: begin
          // read stage then write stage; rdata is mem[rd-1]
          if (rvalid && (req.op == OP_ERASE || rdata != req.value)) begin
            mem[wr[IdxW-1:0]] <= rdata;
            wr <= wr + 1'b1;
          end
          if (rd != count) begin
            rdata <= mem[rd[IdxW-1:0]];
            rd <= rd + 1'b1;
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
          if (rd == count && !rvalid) count <= wr;
        end
        ST_READ: begin
          rdata <= mem[rd[IdxW-1:0]];
          rd <= rd + 1'b1;
        end
        ST_EMIT: if (!busy_out) begin
          out_full <= 1'b1;
          m_value <= rdata;
          m_status <= 1'b0;
          m_last <= (req.op == OP_PRINT) || (rd == stop);
        end
        ST_DROP: if (!busy_out) begin
          out_full <= 1'b1;
          m_value <= '0;
          m_status <= 1'b1;
          m_last <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/positional_list_engine.sv */
// Top level: positional list engine, request queue in front of a list sequencer.
//
// Usage:
//   s_axis carries one request item: req_type, pos, end_pos, value.
//   m_axis returns results: item_value in tdata, last in tlast and
//   status in tuser.
// Operation:
//   Insert shifts one entry per cycle from the list end down to pos, then
//   writes the value; erase and remove compact the list, one entry read and
//   at most one written per cycle; print reads and emits one entry; show
//   reads and emits every entry in turn. A full-list insert gives one
//   status item. A two-entry request queue decouples intake from the
//   sequencer, so requests are taken while the sequencer still works.
// Reset: rst (synchronous, active high) empties the list and the queue.
//   List memory needs no clear: only written entries are ever read.
// Stall: when m_axis_tready is low the result is held in the output
//   register and the sequencer waits; the queue then fills and
//   s_axis_tready drops.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // req_type[2:0], pos[18:3], end_pos[34:19], value[50:35]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // item_value[15:0]
  output logic        m_axis_tlast,  // last
  output logic        m_axis_tuser   // status
);
  import ple_pkg::*;

  req_t s_req, q_req;
  logic q_valid, q_ready;

  assign s_req.op      = op_t'(s_axis_tdata[2:0]);
  assign s_req.pos     = s_axis_tdata[18:3];
  assign s_req.end_pos = s_axis_tdata[34:19];
  assign s_req.value   = s_axis_tdata[50:35];

  ple_front u_front (
    .clk, .rst,
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_req,
    .q_valid, .q_ready, .q_req
  );

  ple_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_req,
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_value(m_axis_tdata), .m_last(m_axis_tlast), .m_status(m_axis_tuser)
  );
endmodule
